### design/fibonacci_mod_matrix_power_top_macros.svh
// Assertion macros shared by the design files.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef FIBONACCI_MOD_MATRIX_POWER_TOP_MACROS_SVH
`define FIBONACCI_MOD_MATRIX_POWER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define FMMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The expression must never be true outside reset.
`define FMMP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define FMMP_ASSERT(lbl, prop, msg)
`define FMMP_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### design/fmmp_pkg.sv
package fmmp_pkg;

  // Width of every residue, exponent and modulus.
  localparam int unsigned WordW = 31;
  typedef logic [WordW-1:0] word_t;

  // Product lanes: two per entry of a 2x2 matrix product.
  localparam int unsigned Lanes = 8;

  // Microprogram counter.
  localparam int unsigned PcW = 3;
  typedef logic [PcW-1:0] pc_t;

  // Microcode operations.
  typedef enum logic [2:0] {
    OP_WAIT,  // take the next input item
    OP_JZN,   // jump when the exponent is zero
    OP_JNB,   // jump when the low exponent bit is clear
    OP_MUL,   // run the eight product lanes and write one matrix
    OP_SHR,   // shift the exponent right, jump when it becomes zero
    OP_JMP,   // unconditional jump
    OP_EMIT   // load the result register and return to wait
  } op_e;

  // Matrix bank: the running product or the running square.
  typedef enum logic {
    BANK_ACC,
    BANK_SQR
  } bank_e;

  typedef struct packed {
    op_e   op;
    bank_e bank;
    pc_t   target;
  } ucode_t;

  // Program addresses.
  localparam pc_t PcWait  = 3'd0;
  localparam pc_t PcZero  = 3'd1;
  localparam pc_t PcBit   = 3'd2;
  localparam pc_t PcMulA  = 3'd3;
  localparam pc_t PcShift = 3'd4;
  localparam pc_t PcMulS  = 3'd5;
  localparam pc_t PcLoop  = 3'd6;
  localparam pc_t PcEmit  = 3'd7;

  // Request from the sequencer to one modular product lane.
  typedef struct packed {
    logic  start;
    word_t mcand;
    word_t mplier;
    word_t modulus;
  } lane_req_t;

  // Sum of two residues below m, reduced by one compare and subtract.
  function automatic word_t mod_add(word_t a, word_t b, word_t m);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WordW-1:0];
  endfunction

  // Control store: square-and-multiply over the exponent bits.
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    case (pc)
      PcWait:  w = '{op: OP_WAIT, bank: BANK_ACC, target: PcZero};
      PcZero:  w = '{op: OP_JZN,  bank: BANK_ACC, target: PcEmit};
      PcBit:   w = '{op: OP_JNB,  bank: BANK_ACC, target: PcShift};
      PcMulA:  w = '{op: OP_MUL,  bank: BANK_ACC, target: PcShift};
      PcShift: w = '{op: OP_SHR,  bank: BANK_ACC, target: PcEmit};
      PcMulS:  w = '{op: OP_MUL,  bank: BANK_SQR, target: PcLoop};
      PcLoop:  w = '{op: OP_JMP,  bank: BANK_ACC, target: PcBit};
      PcEmit:  w = '{op: OP_EMIT, bank: BANK_ACC, target: PcWait};
      default: w = '{op: OP_WAIT, bank: BANK_ACC, target: PcZero};
    endcase
    return w;
  endfunction

endpackage

### design/fmmp_mulmod_lane.sv
module fmmp_mulmod_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmmp_pkg::lane_req_t req_i,
  output logic                busy_o,
  output fmmp_pkg::word_t     prod_o
);
  import fmmp_pkg::*;

  word_t mcand_q;
  word_t mplier_q;
  word_t acc_q;

  // The lane runs while multiplier bits remain.
  assign busy_o = (mplier_q != '0);
  assign prod_o = acc_q;

  // Multiplier bits, consumed low bit first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
    end else if (req_i.start) begin
      mplier_q <= req_i.mplier;
    end else if (busy_o) begin
      mplier_q <= mplier_q >> 1;
    end
  end

  // Double-and-add: each step adds the multiplicand when the bit is set, then doubles it.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= req_i.mcand;
      acc_q   <= '0;
    end else if (busy_o) begin
      if (mplier_q[0]) begin
        acc_q <= mod_add(acc_q, mcand_q, req_i.modulus);
      end
      mcand_q <= mod_add(mcand_q, mcand_q, req_i.modulus);
    end
  end

endmodule

### design/fibonacci_mod_matrix_power_top.sv
// Fibonacci modulo m: for each item (index_n, modulus) the block returns F(n+1) mod m,
// from the 2x2 matrix [[1,1],[1,0]] raised to the power n by square-and-multiply over
// the bits of n. A modulus of zero or one gives 0, and an index of zero gives 1 mod m.
// One item is worked on at a time; the finished result sits in an output register, so
// the next item is taken while it waits. Eight bit-serial double-and-add lanes form
// one matrix product, taking one bit of the widest multiplier entry per cycle, and a
// small microprogram runs them.
`include "fibonacci_mod_matrix_power_top_macros.svh"

module fibonacci_mod_matrix_power_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fmmp_pkg::word_t index_n_i,
  input  fmmp_pkg::word_t modulus_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fmmp_pkg::word_t fib_value_o
);
  import fmmp_pkg::*;

  pc_t       pc_q, pc_d;
  logic      run_q, run_d;
  word_t     n_q, n_d;
  word_t     m_q;
  logic      mzero_q;
  word_t     a_q [4];
  word_t     s_q [4];
  logic      out_valid_q;
  word_t     out_data_q;
  ucode_t    uc;
  logic      in_load;
  logic      lane_start;
  logic      bank_wr;
  logic      out_load;
  logic      out_free;
  logic      any_busy;
  word_t     one_val;
  word_t     row_sum;
  logic      [Lanes-1:0] lane_busy;
  word_t     lane_prod [Lanes];
  word_t     mat_next [4];

  assign uc       = ucode_rom(pc_q);
  assign any_busy = |lane_busy;
  assign out_free = !out_valid_q || !out_stall_i;
  assign one_val  = (modulus_i == word_t'(1)) ? '0 : word_t'(1);
  assign row_sum  = mod_add(a_q[2], a_q[3], m_q);

  assign in_stall_o  = (uc.op != OP_WAIT);
  assign out_valid_o = out_valid_q;
  assign fib_value_o = out_data_q;

  // Sequencer: decode the current control word.
  always_comb begin
    pc_d       = pc_q;
    run_d      = run_q;
    n_d        = n_q;
    in_load    = 1'b0;
    lane_start = 1'b0;
    bank_wr    = 1'b0;
    out_load   = 1'b0;
    case (uc.op)
      OP_WAIT: begin
        if (in_valid_i) begin
          in_load = 1'b1;
          n_d     = index_n_i;
          pc_d    = pc_q + pc_t'(1);
        end
      end
      OP_JZN: begin
        pc_d = (n_q == '0) ? uc.target : pc_q + pc_t'(1);
      end
      OP_JNB: begin
        pc_d = !n_q[0] ? uc.target : pc_q + pc_t'(1);
      end
      OP_MUL: begin
        if (!run_q) begin
          lane_start = 1'b1;
          run_d      = 1'b1;
        end else if (!any_busy) begin
          bank_wr = 1'b1;
          run_d   = 1'b0;
          pc_d    = pc_q + pc_t'(1);
        end
      end
      OP_SHR: begin
        n_d  = n_q >> 1;
        pc_d = (n_q[WordW-1:1] == '0) ? uc.target : pc_q + pc_t'(1);
      end
      OP_JMP: begin
        pc_d = uc.target;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          pc_d     = uc.target;
        end
      end
      default: begin
        pc_d = PcWait;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      run_q <= run_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Eight product lanes: lane l forms x[i][k] * S[k][j] for result entry (i, j).
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    localparam int unsigned Ent = l / 2;
    localparam int unsigned K   = l % 2;
    localparam int unsigned XIx = 2 * (Ent / 2) + K;
    localparam int unsigned YIx = 2 * K + (Ent % 2);
    lane_req_t req;

    assign req.start   = lane_start;
    assign req.mcand   = (uc.bank == BANK_ACC) ? a_q[XIx] : s_q[XIx];
    assign req.mplier  = s_q[YIx];
    assign req.modulus = m_q;

    fmmp_mulmod_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req),
      .busy_o (lane_busy[l]),
      .prod_o (lane_prod[l])
    );
  end

  // Each new matrix entry is the reduced sum of its two products.
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      mat_next[e] = mod_add(lane_prod[2*e], lane_prod[2*e+1], m_q);
    end
  end

  // Exponent, modulus and the two matrix banks.
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    if (in_load) begin
      m_q     <= modulus_i;
      mzero_q <= (modulus_i == '0);
      a_q[0]  <= one_val;
      a_q[1]  <= '0;
      a_q[2]  <= '0;
      a_q[3]  <= one_val;
      s_q[0]  <= one_val;
      s_q[1]  <= one_val;
      s_q[2]  <= one_val;
      s_q[3]  <= '0;
    end else if (bank_wr) begin
      for (int e = 0; e < 4; e++) begin
        if (uc.bank == BANK_ACC) begin
          a_q[e] <= mat_next[e];
        end else begin
          s_q[e] <= mat_next[e];
        end
      end
    end
  end

  // Result register: the second row sum of the power, or zero without a modulus.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mzero_q ? '0 : row_sum;
    end
  end

  `FMMP_ASSERT(a_busy_in_mul, any_busy |-> (uc.op == OP_MUL), "lanes busy outside a multiply step")
  `FMMP_ASSERT(a_load_starts, in_load |=> (pc_q == PcZero), "item taken but program did not advance")
  `FMMP_ASSERT(a_result_range, (out_load && !mzero_q) |=> (out_data_q < $past(m_q)), "result not reduced")
  `FMMP_ASSERT_NEVER(a_no_start_busy, lane_start && any_busy, "lanes restarted while busy")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import fmmp_pkg::word_t;

  // Pacing of the run.
  localparam int unsigned RandomItems = 300;
  localparam int unsigned HoldAt      = 60;     // inputs taken before the long output hold-off
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned DrainAt     = 200;    // random item that waits for an empty pipeline
  localparam int unsigned SteadyLo    = 120;    // stretch of items with no idling on either side
  localparam int unsigned SteadyHi    = 190;
  localparam int unsigned TailCycles  = 2500;
  localparam int unsigned QuietLimit  = 20000;
  localparam word_t       WordMax     = '1;

  typedef struct {
    word_t index_n;
    word_t modulus;
    bit    drain_first;
  } fib_req_t;

  logic  clk_i;
  logic  rst_ni    = 1'b0;
  logic  in_valid  = 1'b0;
  word_t index_n   = '0;
  word_t modulus   = '0;
  logic  out_stall = 1'b1;
  logic  in_stall_o;
  logic  out_valid_o;
  word_t fib_value_o;

  fib_req_t    req_q[$];
  word_t       fib_expected_q[$];
  fib_req_t    next_req;
  logic        in_taken      = 1'b0;
  int unsigned inputs_taken  = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned errors        = 0;
  logic        steady_phase;

  assign steady_phase = (inputs_taken >= SteadyLo) && (inputs_taken < SteadyHi);

  fibonacci_mod_matrix_power_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .index_n_i   (index_n),
    .modulus_i   (modulus),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .fib_value_o (fib_value_o)
  );

  // Product of two residues below m; 64 bits hold it without overflow.
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a * b) % m;
  endfunction

  // F(n+1) mod m from the Fibonacci matrix raised to the power n.
  function automatic word_t fib_mod(word_t n, word_t m);
    logic [63:0] mm;
    logic [63:0] r00, r01, r10, r11;
    logic [63:0] s00, s01, s10, s11;
    logic [63:0] t00, t01, t10, t11;
    word_t       e;
    if (m == '0) begin
      return '0;
    end
    mm  = {33'd0, m};
    e   = n;
    r00 = 64'd1 % mm;
    r01 = 64'd0;
    r10 = 64'd0;
    r11 = 64'd1 % mm;
    s00 = 64'd1 % mm;
    s01 = 64'd1 % mm;
    s10 = 64'd1 % mm;
    s11 = 64'd0;
    while (e != '0) begin
      if (e[0]) begin
        t00 = (mul_mod(r00, s00, mm) + mul_mod(r01, s10, mm)) % mm;
        t01 = (mul_mod(r00, s01, mm) + mul_mod(r01, s11, mm)) % mm;
        t10 = (mul_mod(r10, s00, mm) + mul_mod(r11, s10, mm)) % mm;
        t11 = (mul_mod(r10, s01, mm) + mul_mod(r11, s11, mm)) % mm;
        r00 = t00;
        r01 = t01;
        r10 = t10;
        r11 = t11;
      end
      e = e >> 1;
      if (e != '0) begin
        t00 = (mul_mod(s00, s00, mm) + mul_mod(s01, s10, mm)) % mm;
        t01 = (mul_mod(s00, s01, mm) + mul_mod(s01, s11, mm)) % mm;
        t10 = (mul_mod(s10, s00, mm) + mul_mod(s11, s10, mm)) % mm;
        t11 = (mul_mod(s10, s01, mm) + mul_mod(s11, s11, mm)) % mm;
        s00 = t00;
        s01 = t01;
        s10 = t10;
        s11 = t11;
      end
    end
    return word_t'((r10 + r11) % mm);
  endfunction

  // One line per mismatch, and a count for the final verdict.
  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    errors++;
    $display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Queue one item for the driver.
  task automatic push_req(input word_t n, input word_t m, input bit drain_first);
    fib_req_t r;
    r.index_n     = n;
    r.modulus     = m;
    r.drain_first = drain_first;
    req_q.push_back(r);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: offers the next item once the previous one is gone, with random gaps outside the steady stretch.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (req_q.size() != 0 && !(req_q[0].drain_first && fib_expected_q.size() != 0) &&
          (steady_phase || $urandom_range(99) >= 33)) begin
        next_req = req_q.pop_front();
        in_valid <= 1'b1;
        index_n  <= next_req.index_n;
        modulus  <= next_req.modulus;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long output hold-off, started once after enough items have gone in.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && inputs_taken == HoldAt) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Receiver stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall <= (hold_left != 0) || (!steady_phase && $urandom_range(99) < 33);
    end
  end

  // Monitor: records accepted items, checks each result against the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) begin
        fib_expected_q.push_back(fib_mod(index_n, modulus));
        inputs_taken++;
      end
      if (out_valid_o && !out_stall) begin
        if (fib_expected_q.size() == 0) begin
          report_mismatch("result with no item pending", fib_value_o, '0);
        end else if (fib_value_o !== fib_expected_q[0]) begin
          report_mismatch("fib_value", fib_value_o, fib_expected_q.pop_front());
        end else begin
          void'(fib_expected_q.pop_front());
        end
      end
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  initial begin
    while (quiet_cycles < QuietLimit) @(negedge clk_i);
    $display("fibonacci_mod_matrix_power_top: mismatch");
    $finish;
  end

  // Stimulus, reset and the end of the run.
  initial begin
    word_t n;
    word_t m;

    // Directed: field extremes, index zero, modulus zero and one, exact small values.
    push_req(31'd1, WordMax, 1'b0);
    push_req(WordMax, WordMax, 1'b0);
    push_req(31'd0, 31'd10, 1'b0);
    push_req(31'd0, WordMax, 1'b0);
    push_req(31'd5, 31'd0, 1'b0);
    push_req(31'd0, 31'd0, 1'b0);
    push_req(WordMax, 31'd0, 1'b0);
    push_req(31'd100, 31'd1, 1'b0);
    push_req(WordMax, 31'd1, 1'b0);
    push_req(31'd0, 31'd1, 1'b0);
    push_req(31'd1, 31'd1, 1'b0);
    push_req(31'd2, 31'd2, 1'b0);
    push_req(WordMax, 31'd2, 1'b0);
    push_req(31'd44, WordMax, 1'b0);
    push_req(31'd45, WordMax, 1'b0);
    push_req(31'd46, WordMax, 1'b0);
    push_req(31'h4000_0000, 31'd1000000007, 1'b0);
    push_req(31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
    push_req(31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
    push_req(31'd3, 31'd4, 1'b0);
    push_req(31'd10, 31'd7, 1'b0);

    // Random: mostly short exponents, some medium, a few at full width.
    for (int i = 0; i < RandomItems; i++) begin
      case ($urandom_range(99)) inside
        [0:1]:   n = '0;
        [2:70]:  n = word_t'($urandom_range(1023, 1));
        [71:89]: n = word_t'($urandom_range(32'h000F_FFFF, 1));
        default: n = word_t'($urandom());
      endcase
      case ($urandom_range(99)) inside
        [0:39]:  m = word_t'($urandom());
        [40:59]: m = word_t'($urandom_range(100, 1));
        [60:79]: m = word_t'($urandom_range(65535, 1));
        [80:89]: m = WordMax - word_t'($urandom_range(1000));
        [90:94]: m = 31'd1;
        default: m = '0;
      endcase
      push_req(n, m, i == DrainAt);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid || fib_expected_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("fibonacci_mod_matrix_power_top: match");
    end else begin
      $display("fibonacci_mod_matrix_power_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/fmmp_pkg.sv
design/fmmp_mulmod_lane.sv
design/fibonacci_mod_matrix_power_top.sv
bench/testbench.sv
